// ===== design/hsvd_pkg.sv =====
package hsvd_pkg;

    // Q16 unit value, 0..65536 after clamping
    localparam int unsigned UNIT_W = 17;
    localparam int unsigned RAW_W  = 18;

    typedef logic [UNIT_W-1:0] t_unit;
    typedef logic [RAW_W-1:0]  t_raw;
    typedef logic [2:0]        t_sector;

    localparam t_unit FULL_Q16 = 17'd65536;

    localparam t_sector SEC_0 = 3'd0;
    localparam t_sector SEC_1 = 3'd1;
    localparam t_sector SEC_2 = 3'd2;
    localparam t_sector SEC_3 = 3'd3;
    localparam t_sector SEC_4 = 3'd4;
    localparam t_sector SEC_5 = 3'd5;

    // classified color word handed from the front to the back
    typedef struct packed {
        t_sector sector;
        t_unit   f;
        t_unit   s;
        t_unit   v;
    } t_item;

    function automatic t_unit clamp_unit(input t_raw raw);
        t_unit res;
        if (raw[RAW_W-1]) begin
            res = '0;
        end else if (raw[UNIT_W-1:0] > FULL_Q16) begin
            res = FULL_Q16;
        end else begin
            res = raw[UNIT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/hsvd_front.sv =====
module hsvd_front (
    input  hsvd_pkg::t_raw  i_hue,
    input  hsvd_pkg::t_raw  i_sat,
    input  hsvd_pkg::t_raw  i_val,
    output hsvd_pkg::t_item o_item
);
    import hsvd_pkg::*;

    t_unit       h;
    logic [18:0] h6;
    t_unit       t;
    t_sector     sec;

    always_comb begin
        h   = clamp_unit(i_hue);
        // 6h = 4h + 2h, at most 393216
        h6  = {h, 2'b00} + {1'b0, h, 1'b0};
        sec = h6[18:16];
        t   = h6[16:0];
        // hue of exactly one lands in sector 6, folded into the last one
        o_item.sector = (sec > SEC_5) ? SEC_5 : sec;
        // f = 1 - |t - 1|, so f = t below one and 2 - t above
        o_item.f = t[16] ? (FULL_Q16 - {1'b0, t[15:0]}) : t;
        o_item.s = clamp_unit(i_sat);
        o_item.v = clamp_unit(i_val);
    end

endmodule

// ===== design/hsvd_fifo.sv =====
module hsvd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsvd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hsvd_pkg::t_item o_item
);
    import hsvd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/hsvd_back.sv =====
module hsvd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hsvd_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_blue,
    output logic [15:0]     o_green,
    output logic [15:0]     o_red
);
    import hsvd_pkg::*;

    // floor(q * 65535 / 2^48), q is Q48 and at most 2^48
    function automatic logic [15:0] duty_of(input logic [48:0] q);
        logic [64:0] p;
        p = {q, 16'b0} - {16'b0, q};
        return p[63:48];
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: chroma
    logic [32:0] r_c1;
    t_unit       r_v_1, r_f1;
    t_sector     r_sec1;
    // stage 2: x and m
    logic [32:0] r_c2, r_m2;
    logic [48:0] r_x2;
    t_sector     r_sec2;
    // stage 3: per-channel sums in Q48
    logic [48:0] r_b3, r_g3, r_r3;
    // stage 4: output word
    logic [15:0] r_blue, r_green, r_red;

    logic [48:0] n_b, n_g, n_r, c48, m48;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_blue  = r_blue;
    assign o_green = r_green;
    assign o_red   = r_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        c48 = {r_c2[32:0], 16'b0};
        m48 = {r_m2[32:0], 16'b0};
        n_b = '0;
        n_g = '0;
        n_r = '0;
        unique case (r_sec2)
            SEC_0: begin
                n_r = c48;
                n_g = r_x2;
            end
            SEC_1: begin
                n_r = r_x2;
                n_g = c48;
            end
            SEC_2: begin
                n_g = c48;
                n_b = r_x2;
            end
            SEC_3: begin
                n_g = r_x2;
                n_b = c48;
            end
            SEC_4: begin
                n_r = r_x2;
                n_b = c48;
            end
            default: begin
                n_r = c48;
                n_b = r_x2;
            end
        endcase
        n_b = n_b + m48;
        n_g = n_g + m48;
        n_r = n_r + m48;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_c1   <= 33'(i_item.v * i_item.s);
            r_v_1  <= i_item.v;
            r_f1   <= i_item.f;
            r_sec1 <= i_item.sector;
        end
        if (rdy2 && r_v1) begin
            r_c2   <= r_c1;
            r_x2   <= 49'(r_c1 * r_f1);
            r_m2   <= {r_v_1[16:0], 16'b0} - r_c1;
            r_sec2 <= r_sec1;
        end
        if (rdy3 && r_v2) begin
            r_b3 <= n_b;
            r_g3 <= n_g;
            r_r3 <= n_r;
        end
        if (rdy4 && r_v3) begin
            r_blue  <= duty_of(r_b3);
            r_green <= duty_of(r_g3);
            r_red   <= duty_of(r_r3);
        end
    end

endmodule

// ===== design/hsv_to_rgb_pwm_duty.sv =====
// HSV to RGB PWM duty converter.
// Slave channel: one word per color, tdata = {brightness, saturation, hue},
// each an 18-bit signed Q16 fraction, hue in the lowest bits. Values are
// clamped to 0..1.0 before use.
// Master channel: one word per color, tdata = {red, green, blue} duty, 16 bits
// each, blue in the lowest bits, ready to load into PWM compare registers.
// Throughput: one word per cycle, sustained while m_axis_tready stays high.
// When the queue is empty, an accepted word is queued, moves from the queue
// into back-end stage one and then through stages two and three to stage
// four, the output register, from which it appears on the master side. The
// chroma and x multipliers sit in separate stages.
// The front clamps and classifies the hue sector, then writes into a queue of
// QUEUE_DEPTH words; s_axis_tready is high whenever the queue has room, so it
// does not depend on m_axis_tready in the same cycle.
// When the receiver stalls, the back-end stages fill, then the queue fills,
// and only then does s_axis_tready drop. Nothing is lost or dropped.
// Reset (i_rst_n low, synchronous) empties the queue and the pipeline; no
// word is pending afterwards.
module hsv_to_rgb_pwm_duty #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // hue_in[17:0], saturation_in[35:18],
                                        // brightness_in[53:36], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // blue_duty[15:0], green_duty[31:16],
                                        // red_duty[47:32]
);
    import hsvd_pkg::*;

    t_item front_item, q_item;
    logic  q_full, q_valid, back_ready;

    hsvd_front u_front (
        .i_hue  (s_axis_tdata[17:0]),
        .i_sat  (s_axis_tdata[35:18]),
        .i_val  (s_axis_tdata[53:36]),
        .o_item (front_item)
    );

    hsvd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (back_ready),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    assign s_axis_tready = !q_full;

    hsvd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (back_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_blue  (m_axis_tdata[15:0]),
        .o_green (m_axis_tdata[31:16]),
        .o_red   (m_axis_tdata[47:32])
    );

endmodule

// ===== design/hsvd_checker.sv =====
module hsvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // the queue only fills by taking words
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without an accepted word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

bind hsv_to_rgb_pwm_duty hsvd_checker u_hsvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
